// ===== sv/sbi_pkg.sv =====
// Shared flag type for the segment and box intersection pipeline.
`timescale 1ns / 1ps

package sbi_pkg;

  // Per-word flags that ride with the data from setup to the final compare.
  typedef struct packed {
    logic empty;   // clipped x-span is empty
    logic vert;    // segment is vertical
    logic neg_lo;  // interpolation offset at the low x end is negative
    logic neg_hi;  // interpolation offset at the high x end is negative
  } sbi_flags_t;

endpackage

// ===== sv/sbi_front.sv =====
// Setup stages: x clipping, differences, magnitudes and the two products.
`timescale 1ns / 1ps

module sbi_front
  import sbi_pkg::*;
#(
  parameter int W = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [W-1:0] rect_left,
  input  logic signed [W-1:0] rect_top,
  input  logic signed [W-1:0] rect_right,
  input  logic signed [W-1:0] rect_bottom,
  input  logic signed [W-1:0] seg_x_start,
  input  logic signed [W-1:0] seg_y_start,
  input  logic signed [W-1:0] seg_x_end,
  input  logic signed [W-1:0] seg_y_end,
  output logic                valid,
  output logic [2*W-1:0]      num_lo,
  output logic [2*W-1:0]      num_hi,
  output logic [W-1:0]        den,
  output logic signed [W-1:0] y1,
  output logic signed [W-1:0] y2,
  output logic signed [W-1:0] rt,
  output logic signed [W-1:0] rb,
  output sbi_flags_t          flags
);

  // Stage 1 registers.
  logic                s1_valid;
  logic signed [W-1:0] s1_x1, s1_y1, s1_y2, s1_rl, s1_rr, s1_rt, s1_rb;
  logic signed [W-1:0] s1_sxmin, s1_sxmax;
  logic signed [W:0]   s1_dx, s1_dy;

  // Stage 2 registers.
  logic                s2_valid;
  logic signed [W-1:0] s2_x1, s2_y1, s2_y2, s2_rt, s2_rb, s2_lox, s2_hix;
  logic signed [W:0]   s2_dx, s2_dy;

  // Stage 3 registers.
  logic                s3_valid;
  logic signed [W-1:0] s3_y1, s3_y2, s3_rt, s3_rb;
  logic signed [W:0]   s3_dx, s3_dy, s3_tlo, s3_thi;
  logic                s3_empty, s3_vert;

  // Stage 4 registers.
  logic                s4_valid;
  logic signed [W-1:0] s4_y1, s4_y2, s4_rt, s4_rb;
  logic [W-1:0]        s4_mdx, s4_mdy, s4_mtlo, s4_mthi;
  sbi_flags_t          s4_flags;

  // Combinational values feeding each stage.
  logic signed [W-1:0] sxmin_next, sxmax_next, lox_next, hix_next;
  logic signed [W:0]   dx_next, dy_next, tlo_next, thi_next;
  logic signed [W:0]   mdx_full, mdy_full, mtlo_full, mthi_full;

  // Order the segment's x ends and form the endpoint differences.
  always_comb begin
    sxmin_next = (seg_x_start < seg_x_end) ? seg_x_start : seg_x_end;
    sxmax_next = (seg_x_start > seg_x_end) ? seg_x_start : seg_x_end;
    dx_next    = {seg_x_end[W-1], seg_x_end} - {seg_x_start[W-1], seg_x_start};
    dy_next    = {seg_y_end[W-1], seg_y_end} - {seg_y_start[W-1], seg_y_start};
  end

  // Clip the x-span to the rectangle.
  always_comb begin
    lox_next = (s1_sxmin > s1_rl) ? s1_sxmin : s1_rl;
    hix_next = (s1_sxmax < s1_rr) ? s1_sxmax : s1_rr;
  end

  // Offsets of both clipped ends from the first endpoint.
  always_comb begin
    tlo_next = {s2_lox[W-1], s2_lox} - {s2_x1[W-1], s2_x1};
    thi_next = {s2_hix[W-1], s2_hix} - {s2_x1[W-1], s2_x1};
  end

  // Magnitudes; every one of them stays below 2^W.
  always_comb begin
    mdx_full  = s3_dx[W]  ? -s3_dx  : s3_dx;
    mdy_full  = s3_dy[W]  ? -s3_dy  : s3_dy;
    mtlo_full = s3_tlo[W] ? -s3_tlo : s3_tlo;
    mthi_full = s3_thi[W] ? -s3_thi : s3_thi;
  end

  // Valid bits travel with the data and freeze on a stall.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      valid    <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      valid    <= s4_valid;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_x1    <= seg_x_start;
      s1_y1    <= seg_y_start;
      s1_y2    <= seg_y_end;
      s1_rl    <= rect_left;
      s1_rr    <= rect_right;
      s1_rt    <= rect_top;
      s1_rb    <= rect_bottom;
      s1_sxmin <= sxmin_next;
      s1_sxmax <= sxmax_next;
      s1_dx    <= dx_next;
      s1_dy    <= dy_next;

      s2_x1  <= s1_x1;
      s2_y1  <= s1_y1;
      s2_y2  <= s1_y2;
      s2_rt  <= s1_rt;
      s2_rb  <= s1_rb;
      s2_lox <= lox_next;
      s2_hix <= hix_next;
      s2_dx  <= s1_dx;
      s2_dy  <= s1_dy;

      s3_y1    <= s2_y1;
      s3_y2    <= s2_y2;
      s3_rt    <= s2_rt;
      s3_rb    <= s2_rb;
      s3_dx    <= s2_dx;
      s3_dy    <= s2_dy;
      s3_tlo   <= tlo_next;
      s3_thi   <= thi_next;
      s3_empty <= (s2_lox > s2_hix);
      s3_vert  <= (s2_dx == '0);

      s4_y1           <= s3_y1;
      s4_y2           <= s3_y2;
      s4_rt           <= s3_rt;
      s4_rb           <= s3_rb;
      s4_mdx          <= mdx_full[W-1:0];
      s4_mdy          <= mdy_full[W-1:0];
      s4_mtlo         <= mtlo_full[W-1:0];
      s4_mthi         <= mthi_full[W-1:0];
      s4_flags.empty  <= s3_empty;
      s4_flags.vert   <= s3_vert;
      s4_flags.neg_lo <= s3_dy[W] ^ s3_tlo[W] ^ s3_dx[W];
      s4_flags.neg_hi <= s3_dy[W] ^ s3_thi[W] ^ s3_dx[W];

      // Exact products of the slope numerator and the offsets.
      num_lo <= s4_mdy * s4_mtlo;
      num_hi <= s4_mdy * s4_mthi;
      den    <= s4_mdx;
      y1     <= s4_y1;
      y2     <= s4_y2;
      rt     <= s4_rt;
      rb     <= s4_rb;
      flags  <= s4_flags;
    end
  end

endmodule

// ===== sv/sbi_div_step.sv =====
// One registered step of the restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps

module sbi_div_step #(
  parameter int W = 24
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] den,
  input  logic [W-1:0] rem_in,
  input  logic [W-1:0] nq_in,
  output logic [W-1:0] rem_out,
  output logic [W-1:0] nq_out
);

  // nq holds the dividend bits still to come on top and quotient bits below.
  logic [W:0]   trial;
  logic [W:0]   diff;
  logic         ge;
  logic [W-1:0] rem_next;

  // Shift in the next dividend bit and try to subtract the divisor.
  always_comb begin
    trial    = {rem_in, nq_in[W-1]};
    diff     = trial - {1'b0, den};
    ge       = (trial >= {1'b0, den});
    rem_next = ge ? diff[W-1:0] : trial[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= rem_next;
      nq_out  <= {nq_in[W-2:0], ge};
    end
  end

endmodule

// ===== sv/sbi_back.sv =====
// Final stages: signed y values, ordering, clamping and the hit decision.
`timescale 1ns / 1ps

module sbi_back
  import sbi_pkg::*;
#(
  parameter int W = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [W-1:0]        q_lo,
  input  logic [W-1:0]        q_hi,
  input  logic signed [W-1:0] y1,
  input  logic signed [W-1:0] y2,
  input  logic signed [W-1:0] rt,
  input  logic signed [W-1:0] rb,
  input  sbi_flags_t          flags,
  output logic                out_valid,
  output logic                hit
);

  logic                b1_valid, b2_valid, b3_valid;
  logic signed [W:0]   b1_ya, b1_yb, b2_ylo, b2_yhi, b3_ylo, b3_yhi;
  logic signed [W:0]   b1_rt, b1_rb, b2_rt, b2_rb;
  logic                b1_empty, b2_empty, b3_empty;

  logic signed [W:0]   y1_ext, y2_ext, q_lo_ext, q_hi_ext, ya_next, yb_next;

  // Apply the quotient signs to the first endpoint's y; a vertical segment keeps both endpoint y values.
  always_comb begin
    y1_ext   = {y1[W-1], y1};
    y2_ext   = {y2[W-1], y2};
    q_lo_ext = {1'b0, q_lo};
    q_hi_ext = {1'b0, q_hi};
    if (flags.vert) begin
      ya_next = y1_ext;
      yb_next = y2_ext;
    end else begin
      ya_next = flags.neg_lo ? (y1_ext - q_lo_ext) : (y1_ext + q_lo_ext);
      yb_next = flags.neg_hi ? (y1_ext - q_hi_ext) : (y1_ext + q_hi_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid  <= 1'b0;
      b2_valid  <= 1'b0;
      b3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      b1_valid  <= in_valid;
      b2_valid  <= b1_valid;
      b3_valid  <= b2_valid;
      out_valid <= b3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_ya    <= ya_next;
      b1_yb    <= yb_next;
      b1_rt    <= {rt[W-1], rt};
      b1_rb    <= {rb[W-1], rb};
      b1_empty <= flags.empty;

      // Order the two y values.
      b2_ylo   <= (b1_ya > b1_yb) ? b1_yb : b1_ya;
      b2_yhi   <= (b1_ya > b1_yb) ? b1_ya : b1_yb;
      b2_rt    <= b1_rt;
      b2_rb    <= b1_rb;
      b2_empty <= b1_empty;

      // Clamp to the rectangle's y-span.
      b3_ylo   <= (b2_ylo < b2_rt) ? b2_rt : b2_ylo;
      b3_yhi   <= (b2_yhi > b2_rb) ? b2_rb : b2_yhi;
      b3_empty <= b2_empty;

      // Touching counts as a hit.
      hit <= !b3_empty && (b3_ylo <= b3_yhi);
    end
  end

endmodule

// ===== sv/segment_box_intersect.sv =====
// Throughput: one word per cycle unless a held result stalls the pipeline;
// the divider is one pipeline stage per quotient bit.
// A stalled output freezes the whole pipeline in place; nothing is dropped or repeated.
// Reset (synchronous, active high) clears every stage's valid bit; data is not reset.
`timescale 1ns / 1ps

module segment_box_intersect
  import sbi_pkg::*;
#(
  parameter int COORD_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] rect_left,
  input  logic signed [COORD_BITS-1:0] rect_top,
  input  logic signed [COORD_BITS-1:0] rect_right,
  input  logic signed [COORD_BITS-1:0] rect_bottom,
  input  logic signed [COORD_BITS-1:0] seg_x_start,
  input  logic signed [COORD_BITS-1:0] seg_y_start,
  input  logic signed [COORD_BITS-1:0] seg_x_end,
  input  logic signed [COORD_BITS-1:0] seg_y_end,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         hit
);

  localparam int W = COORD_BITS;

  logic adv;

  // Per divider stage: stage 0 is the setup output.
  logic                valid_s [0:W];
  logic [W-1:0]        den_s   [0:W];
  logic signed [W-1:0] y1_s    [0:W];
  logic signed [W-1:0] y2_s    [0:W];
  logic signed [W-1:0] rt_s    [0:W];
  logic signed [W-1:0] rb_s    [0:W];
  sbi_flags_t          flags_s [0:W];
  logic [W-1:0]        rem_lo  [0:W];
  logic [W-1:0]        nq_lo   [0:W];
  logic [W-1:0]        rem_hi  [0:W];
  logic [W-1:0]        nq_hi   [0:W];

  logic [2*W-1:0]      num_lo, num_hi;

  // The pipeline moves unless a finished word is held at the output.
  assign in_stall = out_valid && out_stall;
  assign adv      = !in_stall;

  sbi_front #(.W(W)) u_front (
    .clk         (clk),
    .rst         (rst),
    .en          (adv),
    .in_valid    (in_valid),
    .rect_left   (rect_left),
    .rect_top    (rect_top),
    .rect_right  (rect_right),
    .rect_bottom (rect_bottom),
    .seg_x_start (seg_x_start),
    .seg_y_start (seg_y_start),
    .seg_x_end   (seg_x_end),
    .seg_y_end   (seg_y_end),
    .valid       (valid_s[0]),
    .num_lo      (num_lo),
    .num_hi      (num_hi),
    .den         (den_s[0]),
    .y1          (y1_s[0]),
    .y2          (y2_s[0]),
    .rt          (rt_s[0]),
    .rb          (rb_s[0]),
    .flags       (flags_s[0])
  );

  // The quotient fits in W bits, so the upper product half is already below
  // the divisor and seeds the remainder.
  assign rem_lo[0] = num_lo[2*W-1:W];
  assign nq_lo[0]  = num_lo[W-1:0];
  assign rem_hi[0] = num_hi[2*W-1:W];
  assign nq_hi[0]  = num_hi[W-1:0];

  // Divider pipeline: two lanes in lockstep, with the sideband carried along.
  for (genvar k = 1; k <= W; k++) begin : g_div
    logic                valid_r;
    logic [W-1:0]        den_r;
    logic signed [W-1:0] y1_r, y2_r, rt_r, rb_r;
    sbi_flags_t          flags_r;

    sbi_div_step #(.W(W)) u_step_lo (
      .clk     (clk),
      .en      (adv),
      .den     (den_s[k-1]),
      .rem_in  (rem_lo[k-1]),
      .nq_in   (nq_lo[k-1]),
      .rem_out (rem_lo[k]),
      .nq_out  (nq_lo[k])
    );

    sbi_div_step #(.W(W)) u_step_hi (
      .clk     (clk),
      .en      (adv),
      .den     (den_s[k-1]),
      .rem_in  (rem_hi[k-1]),
      .nq_in   (nq_hi[k-1]),
      .rem_out (rem_hi[k]),
      .nq_out  (nq_hi[k])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_r <= 1'b0;
      end else if (adv) begin
        valid_r <= valid_s[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        den_r   <= den_s[k-1];
        y1_r    <= y1_s[k-1];
        y2_r    <= y2_s[k-1];
        rt_r    <= rt_s[k-1];
        rb_r    <= rb_s[k-1];
        flags_r <= flags_s[k-1];
      end
    end

    assign valid_s[k] = valid_r;
    assign den_s[k]   = den_r;
    assign y1_s[k]    = y1_r;
    assign y2_s[k]    = y2_r;
    assign rt_s[k]    = rt_r;
    assign rb_s[k]    = rb_r;
    assign flags_s[k] = flags_r;
  end

  sbi_back #(.W(W)) u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (valid_s[W]),
    .q_lo      (nq_lo[W]),
    .q_hi      (nq_hi[W]),
    .y1        (y1_s[W]),
    .y2        (y2_s[W]),
    .rt        (rt_s[W]),
    .rb        (rb_s[W]),
    .flags     (flags_s[W]),
    .out_valid (out_valid),
    .hit       (hit)
  );

endmodule

// ===== sv/sbi_checker.sv =====
// Port-level checks for the intersection pipeline and their bind to the top level.
`timescale 1ns / 1ps

module sbi_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic hit
);

  // Words accepted but not yet delivered.
  logic [7:0] inflight;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + 8'((in_valid && !in_stall) ? 1 : 0)
                           - 8'((out_valid && !out_stall) ? 1 : 0);
    end
  end

  // A held result keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(hit))
    else $error("held result changed");

  // The input is only stalled while a result is held.
  a_stall_cause: assert property (@(posedge clk)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // No result without an accepted word behind it.
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> inflight != 8'd0)
    else $error("result with no word in flight");

endmodule

bind segment_box_intersect sbi_checker u_sbi_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .hit       (hit)
);
